// ===== design/ctsu_pkg.sv =====
// shared constants, codes and types of the capacitive touch sensor
package ctsu_pkg;

  localparam logic [3:0]  CALIB_RUNS  = 4'd10;
  localparam logic [15:0] TIMEOUT_RST = 16'd10000;
  localparam logic [3:0]  PULSES_RST  = 4'd10;
  localparam logic [9:0]  SCALE_RST   = 10'd102;

  localparam int unsigned THR_W       = 21;
  localparam int unsigned RECIP_SHIFT = 40;
  // ceil(2^40 / 1000), exact floor division for dividends below 2^30
  localparam logic [30:0] RECIP_1000  = 31'd1099511628;

  localparam logic [1:0] OP_TICK      = 2'd0;
  localparam logic [1:0] OP_MEASURE   = 2'd1;
  localparam logic [1:0] OP_CALIBRATE = 2'd2;

  localparam logic [1:0] OUT_UNTOUCHED = 2'd0;
  localparam logic [1:0] OUT_TOUCHED   = 2'd1;
  localparam logic [1:0] OUT_TIMEOUT   = 2'd2;
  localparam logic [1:0] OUT_CALIB     = 2'd3;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_PULSES  = 2'd1;
  localparam logic [1:0] REG_SCALE   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CHARGE,
    PH_DISCHARGE
  } phase_t;

  typedef struct packed {
    logic [15:0] measured_total;
    logic [1:0]  outcome;
    logic        done_res;
    logic        busy_res;
    logic        send_level;
  } stage_t;

endpackage

// ===== design/capacitive_touch_sensor_unit.sv =====
// capacitive touch pad charge-time sensor, top level
//
//  port group        | dir | contents
//  s_tvalid/tready   | in  | s_tdata: operation [1:0], receive_level [2]
//  m_tvalid/tready   | out | m_tdata: send_level [0], busy_res [1], done_res [2],
//                    |     |   outcome [4:3], measured_total [20:5], threshold_value [41:21]
//  cfg_we/index/data | in  | 0 timeout_ticks, 1 pulses_per_measure, 2 threshold_scale
//
//  one item per clock unless stalled; results go through stage a, then output stage b
//  the new threshold is formed by a reciprocal multiply in the cycle after calibration ends
//  sync reset restores config, state, threshold and valid flags at once, no clearing pass
//  a stalled output holds its result and input keeps flowing until both stages are full
module capacitive_touch_sensor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // operation [1:0], receive_level [2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // send_level, busy_res, done_res, outcome,
                                 // measured_total, threshold_value
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] timeout_ticks;
  logic [3:0]  pulses_per_measure;
  logic [9:0]  threshold_scale;

  ctsu_pkg::phase_t phase, phase_next;
  logic                            calibrating, calibrating_next;
  logic [3:0]                      pulses_left, pulses_left_next;
  logic [15:0]                     tick_total, tick_total_next;
  logic [3:0]                      runs_left, runs_left_next;
  logic signed [ctsu_pkg::THR_W-1:0] calibration_sum, calibration_sum_next;
  logic signed [ctsu_pkg::THR_W-1:0] calibrated_threshold;

  logic [1:0]  op;
  logic        rx;
  logic        counting;
  logic        timed_out;
  logic        finished;
  logic        cal_finish;
  logic [15:0] total_inc;
  logic [3:0]  pulses_dec;
  logic [3:0]  pulses_init;
  logic [3:0]  runs_dec;
  logic signed [ctsu_pkg::THR_W-1:0] sum_add;
  logic signed [ctsu_pkg::THR_W-1:0] sum_acc;
  logic [ctsu_pkg::THR_W-1:0]        sum_mag;
  logic [29:0]                       thr_prod;
  ctsu_pkg::stage_t                  res;

  logic                              thr_pend;
  logic                              thr_neg;
  logic [29:0]                       thr_mag;
  logic [60:0]                       quot_full;
  logic [ctsu_pkg::THR_W-1:0]        thr_quot;
  logic signed [ctsu_pkg::THR_W-1:0] thr_new;

  logic                              accept;
  logic                              b_load;
  logic                              a_valid;
  ctsu_pkg::stage_t                  a_res;
  logic                              b_valid;
  ctsu_pkg::stage_t                  b_res;
  logic [ctsu_pkg::THR_W-1:0]        b_thr;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !a_valid || !b_valid || m_tready;
  assign b_load   = a_valid && (!b_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks      <= ctsu_pkg::TIMEOUT_RST;
      pulses_per_measure <= ctsu_pkg::PULSES_RST;
      threshold_scale    <= ctsu_pkg::SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ctsu_pkg::REG_TIMEOUT: timeout_ticks      <= cfg_data;
        ctsu_pkg::REG_PULSES:  pulses_per_measure <= cfg_data[3:0];
        ctsu_pkg::REG_SCALE:   threshold_scale    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    op                   = s_tdata[1:0];
    rx                   = s_tdata[2];
    phase_next           = phase;
    calibrating_next     = calibrating;
    pulses_left_next     = pulses_left;
    tick_total_next      = tick_total;
    runs_left_next       = runs_left;
    calibration_sum_next = calibration_sum;
    cal_finish           = 1'b0;
    finished             = 1'b0;
    res                  = '0;

    counting    = (phase == ctsu_pkg::PH_CHARGE) ? !rx : rx;
    total_inc   = (counting && (tick_total < timeout_ticks)) ? tick_total + 16'd1 : tick_total;
    timed_out   = total_inc >= timeout_ticks;
    pulses_dec  = pulses_left - 4'd1;
    pulses_init = (pulses_per_measure == 4'd0) ? 4'd1 : pulses_per_measure;
    runs_dec    = runs_left - 4'd1;
    sum_add     = timed_out ? -21'sd1 : $signed({5'b0, total_inc});
    sum_acc     = calibration_sum + sum_add;
    sum_mag     = sum_acc[ctsu_pkg::THR_W-1] ? -sum_acc : sum_acc;
    thr_prod    = sum_mag[19:0] * threshold_scale;

    unique case (phase)
      ctsu_pkg::PH_IDLE: begin
        if (op == ctsu_pkg::OP_MEASURE) begin
          calibrating_next = 1'b0;
          phase_next       = ctsu_pkg::PH_CHARGE;
          pulses_left_next = pulses_init;
          tick_total_next  = '0;
        end else if (op == ctsu_pkg::OP_CALIBRATE) begin
          calibrating_next     = 1'b1;
          runs_left_next       = ctsu_pkg::CALIB_RUNS;
          calibration_sum_next = '0;
          phase_next           = ctsu_pkg::PH_CHARGE;
          pulses_left_next     = pulses_init;
          tick_total_next      = '0;
        end
      end
      ctsu_pkg::PH_CHARGE, ctsu_pkg::PH_DISCHARGE: begin
        if (op == ctsu_pkg::OP_TICK) begin
          tick_total_next = total_inc;
          if (timed_out) begin
            finished = 1'b1;
          end else if (!counting) begin
            if (phase == ctsu_pkg::PH_CHARGE) begin
              phase_next = ctsu_pkg::PH_DISCHARGE;
            end else begin
              pulses_left_next = pulses_dec;
              if (pulses_dec == 4'd0) begin
                finished = 1'b1;
              end else begin
                phase_next = ctsu_pkg::PH_CHARGE;
              end
            end
          end
          if (finished) begin
            phase_next = ctsu_pkg::PH_IDLE;
            if (!calibrating) begin
              res.done_res       = 1'b1;
              res.measured_total = total_inc;
              if (timed_out) begin
                res.outcome = ctsu_pkg::OUT_TIMEOUT;
              end else if ($signed({5'b0, total_inc}) > calibrated_threshold) begin
                res.outcome = ctsu_pkg::OUT_TOUCHED;
              end else begin
                res.outcome = ctsu_pkg::OUT_UNTOUCHED;
              end
            end else begin
              calibration_sum_next = sum_acc;
              runs_left_next       = runs_dec;
              if (runs_dec == 4'd0) begin
                cal_finish         = 1'b1;
                calibrating_next   = 1'b0;
                res.done_res       = 1'b1;
                res.outcome        = ctsu_pkg::OUT_CALIB;
                res.measured_total = total_inc;
              end else begin
                phase_next       = ctsu_pkg::PH_CHARGE;
                pulses_left_next = pulses_init;
                tick_total_next  = '0;
              end
            end
          end
        end
      end
      default: phase_next = ctsu_pkg::PH_IDLE;
    endcase

    res.send_level = phase_next == ctsu_pkg::PH_CHARGE;
    res.busy_res   = phase_next != ctsu_pkg::PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ctsu_pkg::PH_IDLE;
      calibrating     <= 1'b0;
      pulses_left     <= '0;
      tick_total      <= '0;
      runs_left       <= '0;
      calibration_sum <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      calibrating     <= calibrating_next;
      pulses_left     <= pulses_left_next;
      tick_total      <= tick_total_next;
      runs_left       <= runs_left_next;
      calibration_sum <= calibration_sum_next;
    end
  end

  // threshold = trunc(sum * scale / 1000), sign and magnitude split
  assign quot_full = thr_mag * ctsu_pkg::RECIP_1000;
  assign thr_quot  = quot_full[ctsu_pkg::RECIP_SHIFT +: ctsu_pkg::THR_W];
  assign thr_new   = thr_neg ? -$signed(thr_quot) : $signed(thr_quot);

  always_ff @(posedge clk) begin
    if (accept && cal_finish) begin
      thr_neg <= sum_acc[ctsu_pkg::THR_W-1];
      thr_mag <= thr_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_pend             <= 1'b0;
      calibrated_threshold <= '0;
    end else begin
      thr_pend <= accept && cal_finish;
      if (thr_pend) begin
        calibrated_threshold <= thr_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (b_load) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= 1'b1;
    end else if (m_tready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_res <= a_res;
      b_thr <= thr_pend ? thr_new : calibrated_threshold;
    end
  end

  assign m_tvalid = b_valid;
  assign m_tdata  = {6'b0, b_thr, b_res};

endmodule

// ===== design/ctsu_checker.sv =====
// port-level checks for the capacitive touch sensor, bound to the top level
module ctsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // a waiting result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // a finished run leaves the block idle
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0])
    else $error("done item still busy");

  // no outcome or total without done
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |->
      m_tdata[4:3] == ctsu_pkg::OUT_UNTOUCHED && m_tdata[20:5] == 16'd0)
    else $error("outcome without done");

  // the charge level is driven only during a run
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("send level high while idle");

endmodule

bind capacitive_touch_sensor_unit ctsu_checker u_ctsu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/tb.sv =====
// scoreboard checked stimulus for the capacitive touch sensor unit
class touch_scoreboard;

  typedef struct packed {
    logic [20:0] threshold_value;
    logic [15:0] measured_total;
    logic [1:0]  outcome;
    logic        done_res;
    logic        busy_res;
    logic        send_level;
  } touch_result_t;

  logic [15:0]      timeout_cfg;
  logic [3:0]       pulses_cfg;
  logic [9:0]       scale_cfg;

  ctsu_pkg::phase_t phase;
  bit               calibrating;
  logic [3:0]       pulses_left;
  logic [15:0]      tick_total;
  logic [3:0]       runs_left;
  int               calib_sum;
  int               threshold;

  touch_result_t    pending_readings[$];
  int               errors;
  int               readings_seen;

  function new();
    timeout_cfg   = ctsu_pkg::TIMEOUT_RST;
    pulses_cfg    = ctsu_pkg::PULSES_RST;
    scale_cfg     = ctsu_pkg::SCALE_RST;
    phase         = ctsu_pkg::PH_IDLE;
    calibrating   = 1'b0;
    pulses_left   = '0;
    tick_total    = '0;
    runs_left     = '0;
    calib_sum     = 0;
    threshold     = 0;
    errors        = 0;
    readings_seen = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      ctsu_pkg::REG_TIMEOUT: timeout_cfg = val;
      ctsu_pkg::REG_PULSES:  pulses_cfg  = val[3:0];
      ctsu_pkg::REG_SCALE:   scale_cfg   = val[9:0];
      default: ;
    endcase
  endfunction

  function void start_pulse_train();
    phase       = ctsu_pkg::PH_CHARGE;
    pulses_left = (pulses_cfg == 4'd0) ? 4'd1 : pulses_cfg;
    tick_total  = '0;
  endfunction

  function int pending();
    return pending_readings.size();
  endfunction

  // advance the sensor by one accepted item and queue the reading it gives
  function void note_item(logic [1:0] op, logic rx);
    touch_result_t r;
    bit            counting;
    bit            finished;
    bit            timed_out;
    longint        prod;
    longint        quot;
    logic [20:0]   bits;
    r         = '0;
    finished  = 1'b0;
    timed_out = 1'b0;
    if (phase == ctsu_pkg::PH_IDLE) begin
      if (op == ctsu_pkg::OP_MEASURE) begin
        calibrating = 1'b0;
        start_pulse_train();
      end else if (op == ctsu_pkg::OP_CALIBRATE) begin
        calibrating = 1'b1;
        runs_left   = ctsu_pkg::CALIB_RUNS;
        calib_sum   = 0;
        start_pulse_train();
      end
    end else if (op == ctsu_pkg::OP_TICK) begin
      counting = (phase == ctsu_pkg::PH_CHARGE) ? (rx == 1'b0) : (rx == 1'b1);
      if (counting && tick_total < timeout_cfg) tick_total = tick_total + 16'd1;
      if (tick_total >= timeout_cfg) begin
        finished  = 1'b1;
        timed_out = 1'b1;
      end else if (!counting) begin
        if (phase == ctsu_pkg::PH_CHARGE) begin
          phase = ctsu_pkg::PH_DISCHARGE;
        end else begin
          pulses_left = pulses_left - 4'd1;
          if (pulses_left == 4'd0) finished = 1'b1;
          else phase = ctsu_pkg::PH_CHARGE;
        end
      end
      if (finished) begin
        phase = ctsu_pkg::PH_IDLE;
        if (!calibrating) begin
          r.done_res       = 1'b1;
          r.measured_total = tick_total;
          if (timed_out) r.outcome = ctsu_pkg::OUT_TIMEOUT;
          else if (int'(tick_total) > threshold) r.outcome = ctsu_pkg::OUT_TOUCHED;
          else r.outcome = ctsu_pkg::OUT_UNTOUCHED;
        end else begin
          calib_sum = calib_sum + (timed_out ? -1 : int'(tick_total));
          runs_left = runs_left - 4'd1;
          if (runs_left == 4'd0) begin
            prod        = longint'(calib_sum) * longint'(scale_cfg);
            quot        = prod / 1000;
            bits        = quot[20:0];
            threshold   = int'($signed(bits));
            calibrating = 1'b0;
            r.done_res       = 1'b1;
            r.outcome        = ctsu_pkg::OUT_CALIB;
            r.measured_total = tick_total;
          end else begin
            start_pulse_train();
          end
        end
      end
    end
    r.send_level      = (phase == ctsu_pkg::PH_CHARGE);
    r.busy_res        = (phase != ctsu_pkg::PH_IDLE);
    r.threshold_value = threshold[20:0];
    pending_readings.push_back(r);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("reading %0d: %s", readings_seen, msg);
  endtask

  task check_reading(logic [47:0] data);
    touch_result_t want;
    touch_result_t got;
    if (pending_readings.size() == 0) begin
      report("reading with nothing expected");
    end else begin
      want = pending_readings.pop_front();
      got  = data[41:0];
      if (data[47:42] != 6'd0) report($sformatf("pad bits %b", data[47:42]));
      if (got.send_level != want.send_level)
        report($sformatf("send_level %0d want %0d", got.send_level, want.send_level));
      if (got.busy_res != want.busy_res)
        report($sformatf("busy_res %0d want %0d", got.busy_res, want.busy_res));
      if (got.done_res != want.done_res)
        report($sformatf("done_res %0d want %0d", got.done_res, want.done_res));
      if (got.outcome != want.outcome)
        report($sformatf("outcome %0d want %0d", got.outcome, want.outcome));
      if (got.measured_total != want.measured_total)
        report($sformatf("measured_total %0d want %0d", got.measured_total,
                         want.measured_total));
      if (got.threshold_value != want.threshold_value)
        report($sformatf("threshold_value %0d want %0d", $signed(got.threshold_value),
                         $signed(want.threshold_value)));
    end
    readings_seen++;
  endtask

  task check_leftovers();
    if (pending_readings.size() != 0)
      report($sformatf("%0d readings never arrived", pending_readings.size()));
  endtask

endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE        = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         LONG_HOLD      = 80;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // operation [1:0], receive_level [2]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // send_level, busy_res, done_res, outcome [4:3],
                          // measured_total [20:5], threshold_value [41:21]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  touch_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int quiet          = 0;

  capacitive_touch_sensor_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: check, then choose next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reading(m_tdata);
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task send_item(input logic [1:0] op, input logic rx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, rx, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(op, rx);
  endtask

  task wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task configure(input logic [15:0] tmo, input logic [3:0] pul, input logic [9:0] scl);
    cfg_we    <= 1'b1;
    cfg_index <= ctsu_pkg::REG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    sb.write_reg(ctsu_pkg::REG_TIMEOUT, tmo);
    cfg_index <= ctsu_pkg::REG_PULSES;
    cfg_data  <= {12'd0, pul};
    @(posedge clk);
    sb.write_reg(ctsu_pkg::REG_PULSES, {12'd0, pul});
    cfg_index <= ctsu_pkg::REG_SCALE;
    cfg_data  <= {6'd0, scl};
    @(posedge clk);
    sb.write_reg(ctsu_pkg::REG_SCALE, {6'd0, scl});
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed pulse trains, with some busy starts and dead items
  task random_items(input int n, input int count_pct);
    int   r;
    logic level;
    repeat (n) begin
      r = $urandom_range(99);
      if (sb.phase == ctsu_pkg::PH_IDLE) begin
        if (r < 8) send_item((r < 4) ? ctsu_pkg::OP_TICK : OP_NONE, 1'($urandom_range(1)));
        else if (r < 62) send_item(ctsu_pkg::OP_MEASURE, 1'($urandom_range(1)));
        else send_item(ctsu_pkg::OP_CALIBRATE, 1'($urandom_range(1)));
      end else if (r < 5) begin
        send_item((r < 2) ? ctsu_pkg::OP_MEASURE :
                  (r < 4) ? ctsu_pkg::OP_CALIBRATE : OP_NONE,
                  1'($urandom_range(1)));
      end else begin
        level = (sb.phase == ctsu_pkg::PH_CHARGE) ? 1'b0 : 1'b1;
        send_item(ctsu_pkg::OP_TICK, ($urandom_range(99) < count_pct) ? level : ~level);
      end
    end
  endtask

  initial begin
    int          n;
    int          pct;
    logic [15:0] tmo;
    logic [3:0]  pul;
    logic [9:0]  scl;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    m_tready  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // idle ticks, dead code, busy starts, a touch and a timeout
    configure(16'd3, 4'd1, 10'd1023);
    send_item(ctsu_pkg::OP_TICK, 1'b0);
    send_item(ctsu_pkg::OP_TICK, 1'b1);
    send_item(OP_NONE, 1'b1);
    send_item(ctsu_pkg::OP_MEASURE, 1'b0);
    send_item(ctsu_pkg::OP_CALIBRATE, 1'b1);
    send_item(OP_NONE, 1'b0);
    send_item(ctsu_pkg::OP_TICK, 1'b0);
    send_item(ctsu_pkg::OP_TICK, 1'b1);
    send_item(ctsu_pkg::OP_TICK, 1'b1);
    send_item(ctsu_pkg::OP_TICK, 1'b0);
    send_item(ctsu_pkg::OP_MEASURE, 1'b1);
    repeat (3) send_item(ctsu_pkg::OP_TICK, 1'b0);
    wait_drained();

    // calibration of all timeouts drives the threshold negative
    configure(16'd1, 4'd1, 10'd1023);
    send_item(ctsu_pkg::OP_CALIBRATE, 1'b0);
    repeat (10) send_item(ctsu_pkg::OP_TICK, 1'b0);
    send_item(ctsu_pkg::OP_MEASURE, 1'b1);
    send_item(ctsu_pkg::OP_TICK, 1'b1);
    send_item(ctsu_pkg::OP_TICK, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          tmo = ctsu_pkg::TIMEOUT_RST;
          pul = ctsu_pkg::PULSES_RST;
          scl = ctsu_pkg::SCALE_RST;
          n   = 200;
          pct = 50;
        end
        1: begin tmo = 16'd0; pul = 4'd0; scl = 10'd0; n = 100; pct = 70; end
        2: begin tmo = 16'hFFFF; pul = 4'd15; scl = 10'd1023; n = 200; pct = 40; end
        3: begin tmo = 16'd1; pul = 4'd1; scl = 10'd500; n = 100; pct = 70; end
        default: begin
          tmo = 16'($urandom_range(2, 40));
          pul = 4'($urandom_range(1, 4));
          scl = 10'($urandom_range(1023));
          n   = 125;
          pct = $urandom_range(55, 85);
        end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      configure(tmo, pul, scl);
      if (ph == 4) hold_req = 1'b1;
      if (ph == 5) begin
        random_items(n / 2, pct);
        wait_drained();
        random_items(n - n / 2, pct);
      end else begin
        random_items(n, pct);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    sb.check_leftovers();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
